// File: hw/rtl/stl_pkg.sv
// Shared constants, token type codes and character-class functions for the source token lexer.
package stl_pkg;

    // Defaults for the top-level parameters
    localparam int PREFIX_BYTES_DEF = 8;
    localparam int OFFSET_BITS_DEF  = 32;

    // Field widths fixed by the token format
    localparam int CHAR_BITS   = 8;
    localparam int TYPE_BITS   = 6;
    localparam int START_BITS  = 32;
    localparam int LEN_BITS    = 16;
    localparam int MODE_BITS   = 3;
    localparam int KW_COUNT    = 10;
    localparam int KW_BYTES    = 8;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Scanner modes
    localparam logic [MODE_BITS-1:0] MODE_EMPTY = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_IDENT = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_INT   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_FLOAT = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_OP    = 3'd4;

    // Token type codes
    localparam logic [TYPE_BITS-1:0] TOK_IDENT   = 6'd0;
    localparam logic [TYPE_BITS-1:0] TOK_KW_LAST = 6'd10;
    localparam logic [TYPE_BITS-1:0] TOK_INT     = 6'd11;
    localparam logic [TYPE_BITS-1:0] TOK_FLOAT   = 6'd12;
    localparam logic [TYPE_BITS-1:0] TOK_PLUS    = 6'd13;
    localparam logic [TYPE_BITS-1:0] TOK_MINUS   = 6'd14;
    localparam logic [TYPE_BITS-1:0] TOK_STAR    = 6'd15;
    localparam logic [TYPE_BITS-1:0] TOK_SLASH   = 6'd16;
    localparam logic [TYPE_BITS-1:0] TOK_PCT     = 6'd17;
    localparam logic [TYPE_BITS-1:0] TOK_LT      = 6'd18;
    localparam logic [TYPE_BITS-1:0] TOK_GT      = 6'd19;
    localparam logic [TYPE_BITS-1:0] TOK_COLON   = 6'd20;
    localparam logic [TYPE_BITS-1:0] TOK_ASSIGN  = 6'd21;
    localparam logic [TYPE_BITS-1:0] TOK_SEMI    = 6'd22;
    localparam logic [TYPE_BITS-1:0] TOK_COMMA   = 6'd23;
    localparam logic [TYPE_BITS-1:0] TOK_LPAREN  = 6'd24;
    localparam logic [TYPE_BITS-1:0] TOK_RPAREN  = 6'd25;
    localparam logic [TYPE_BITS-1:0] TOK_LBRACK  = 6'd26;
    localparam logic [TYPE_BITS-1:0] TOK_RBRACK  = 6'd27;
    localparam logic [TYPE_BITS-1:0] TOK_LBRACE  = 6'd28;
    localparam logic [TYPE_BITS-1:0] TOK_RBRACE  = 6'd29;
    localparam logic [TYPE_BITS-1:0] TOK_NOT     = 6'd30;
    localparam logic [TYPE_BITS-1:0] TOK_LE      = 6'd31;
    localparam logic [TYPE_BITS-1:0] TOK_GE      = 6'd32;
    localparam logic [TYPE_BITS-1:0] TOK_EQ      = 6'd33;
    localparam logic [TYPE_BITS-1:0] TOK_NE      = 6'd34;
    localparam logic [TYPE_BITS-1:0] TOK_ANDAND  = 6'd35;
    localparam logic [TYPE_BITS-1:0] TOK_OROR    = 6'd36;
    localparam logic [TYPE_BITS-1:0] TOK_ERROR   = 6'd37;

    // Characters with a role of their own
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_BITS-1:0] CH_LOW_X  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_PCT    = 8'h25;
    localparam logic [CHAR_BITS-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_BITS-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_BITS-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_BITS-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_BITS-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_BITS-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_BITS-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_BITS-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_BITS-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_BITS-1:0] CH_BANG   = 8'h21;
    localparam logic [CHAR_BITS-1:0] CH_AMP    = 8'h26;
    localparam logic [CHAR_BITS-1:0] CH_BAR    = 8'h7C;

    // Keyword text, first byte in the low bits, zero padded
    localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0074_736E_6F63,   // const
        64'h0000_0000_6469_6F76,   // void
        64'h0000_0000_0074_6E69,   // int
        64'h0000_0074_616F_6C66,   // float
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6C65,   // else
        64'h0000_0065_6C69_6877,   // while
        64'h6575_6E69_746E_6F63,   // continue
        64'h0000_006B_6165_7262,   // break
        64'h0000_6E72_7574_6572    // return
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd4, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd8, 4'd5, 4'd6
    };

    // Character classes
    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word_start(input logic [CHAR_BITS-1:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_hex_part(input logic [CHAR_BITS-1:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)
            || (c == CH_LOW_X) || (c == CH_UP_X);
    endfunction

    function automatic logic is_opchar(input logic [CHAR_BITS-1:0] c);
        logic hit;
        case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_LT, CH_GT, CH_EQ,
            CH_COLON, CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
            CH_LBRACE, CH_RBRACE, CH_BANG, CH_AMP, CH_BAR, CH_COMMA: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Second byte extends a one-byte operator into a two-byte one
    function automatic logic pair_valid(input logic [CHAR_BITS-1:0] a,
                                        input logic [CHAR_BITS-1:0] b);
        return ((b == CH_EQ) && (a == CH_LT || a == CH_GT || a == CH_EQ || a == CH_BANG))
            || (a == CH_AMP && b == CH_AMP) || (a == CH_BAR && b == CH_BAR);
    endfunction

    // Operator type from the first two bytes; a lone & or | is an error
    function automatic logic [TYPE_BITS-1:0] op_type(input logic [CHAR_BITS-1:0] b0,
                                                     input logic [CHAR_BITS-1:0] b1,
                                                     input logic [LEN_BITS-1:0] len);
        logic [TYPE_BITS-1:0] t;
        t = TOK_ERROR;
        if (len == LEN_BITS'(1))
        begin
            case (b0)
                CH_PLUS:   t = TOK_PLUS;
                CH_MINUS:  t = TOK_MINUS;
                CH_STAR:   t = TOK_STAR;
                CH_SLASH:  t = TOK_SLASH;
                CH_PCT:    t = TOK_PCT;
                CH_LT:     t = TOK_LT;
                CH_GT:     t = TOK_GT;
                CH_COLON:  t = TOK_COLON;
                CH_EQ:     t = TOK_ASSIGN;
                CH_SEMI:   t = TOK_SEMI;
                CH_COMMA:  t = TOK_COMMA;
                CH_LPAREN: t = TOK_LPAREN;
                CH_RPAREN: t = TOK_RPAREN;
                CH_LBRACK: t = TOK_LBRACK;
                CH_RBRACK: t = TOK_RBRACK;
                CH_LBRACE: t = TOK_LBRACE;
                CH_RBRACE: t = TOK_RBRACE;
                CH_BANG:   t = TOK_NOT;
                default:   t = TOK_ERROR;
            endcase
        end
        else if (len == LEN_BITS'(2))
        begin
            if (b1 == CH_EQ)
            begin
                case (b0)
                    CH_LT:   t = TOK_LE;
                    CH_GT:   t = TOK_GE;
                    CH_EQ:   t = TOK_EQ;
                    CH_BANG: t = TOK_NE;
                    default: t = TOK_ERROR;
                endcase
            end
            else if (b0 == CH_AMP && b1 == CH_AMP)
                t = TOK_ANDAND;
            else if (b0 == CH_BAR && b1 == CH_BAR)
                t = TOK_OROR;
        end
        return t;
    endfunction

    // Identifier or keyword; bytes past the lexeme end are held at zero
    function automatic logic [TYPE_BITS-1:0] ident_type(input logic [KW_BYTES*8-1:0] text,
                                                        input logic [LEN_BITS-1:0] len);
        logic [TYPE_BITS-1:0] t;
        t = TOK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (len == LEN_BITS'(KW_LEN[k]) && text == KW_TEXT[k])
                t = TYPE_BITS'(k + 1);
        end
        return t;
    endfunction

endpackage

// File: hw/rtl/source_token_lexer_core.sv
// Lexical scanner: one source byte per item in, one token item out when a lexeme ends or a stray byte is flagged.
// Flow: a byte accepted into the input register is scanned there; its token, if any, goes
//   to the result register when the byte advances. Throughput: one byte per cycle,
//   set by the single mode/offset update per scanned byte, unless a token waits on token_stall.
// Reset (rst_n low, asynchronous): empty mode, offset, lexeme start and length cleared,
//   input and result registers empty.
module source_token_lexer_core #(
    parameter int PREFIX_BYTES = stl_pkg::PREFIX_BYTES_DEF,
    parameter int OFFSET_BITS  = stl_pkg::OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             char_valid,
    output logic                             char_stall,
    input  logic [stl_pkg::CHAR_BITS-1:0]    char_code,
    output logic                             token_valid,
    input  logic                             token_stall,
    output logic [stl_pkg::TYPE_BITS-1:0]    token_type,
    output logic [stl_pkg::START_BITS-1:0]   token_start,
    output logic [stl_pkg::LEN_BITS-1:0]     token_length
);

    localparam int PREFIX_W = PREFIX_BYTES * stl_pkg::CHAR_BITS;

    // Input register
    logic                          byte_valid_reg;
    logic [stl_pkg::CHAR_BITS-1:0] byte_reg;

    // Scanner state
    logic [stl_pkg::MODE_BITS-1:0] mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]        offset_reg;
    logic [OFFSET_BITS-1:0]        start_reg, start_next;
    logic [stl_pkg::LEN_BITS-1:0]  length_reg, length_next;
    logic [PREFIX_W-1:0]           prefix_reg, prefix_next;

    // Result register
    logic                          token_valid_reg, token_valid_next;
    logic [stl_pkg::TYPE_BITS-1:0] type_reg;
    logic [stl_pkg::START_BITS-1:0] tstart_reg;
    logic [stl_pkg::LEN_BITS-1:0]  tlength_reg;

    // Scan results for the byte in the input register
    logic                          emit;
    logic [stl_pkg::TYPE_BITS-1:0] emit_type;
    logic [OFFSET_BITS-1:0]        emit_start;
    logic [stl_pkg::LEN_BITS-1:0]  emit_len;
    logic [stl_pkg::START_BITS-1:0] emit_start_word;
    logic                          advance;
    logic                          char_take;

    // Lexeme type of the lexeme held now
    function automatic logic [stl_pkg::TYPE_BITS-1:0] lexeme_type(
        input logic [stl_pkg::MODE_BITS-1:0] m,
        input logic [PREFIX_W-1:0]           p,
        input logic [stl_pkg::LEN_BITS-1:0]  len);
        logic [stl_pkg::TYPE_BITS-1:0] t;
        case (m)
            stl_pkg::MODE_IDENT: t = stl_pkg::ident_type(p[stl_pkg::KW_BYTES*8-1:0], len);
            stl_pkg::MODE_INT:   t = stl_pkg::TOK_INT;
            stl_pkg::MODE_FLOAT: t = stl_pkg::TOK_FLOAT;
            default:             t = stl_pkg::op_type(p[7:0], p[15:8], len);
        endcase
        return t;
    endfunction

    // Scan step
    always_comb
    begin
        logic [stl_pkg::CHAR_BITS-1:0] c;
        logic                          keep;
        logic                          ends;
        logic [stl_pkg::MODE_BITS-1:0] new_mode;
        logic [stl_pkg::LEN_BITS-1:0]  len_sat;

        c           = byte_reg;
        mode_next   = mode_reg;
        start_next  = start_reg;
        length_next = length_reg;
        prefix_next = prefix_reg;
        emit        = 1'b0;
        emit_type   = stl_pkg::TOK_ERROR;
        emit_start  = start_reg;
        emit_len    = length_reg;
        ends        = 1'b0;
        new_mode    = stl_pkg::MODE_EMPTY;
        len_sat     = (length_reg != stl_pkg::LEN_MAX) ? length_reg + 1'b1 : stl_pkg::LEN_MAX;

        case (mode_reg)
            stl_pkg::MODE_IDENT: keep = stl_pkg::is_word_start(c) || stl_pkg::is_digit(c);
            stl_pkg::MODE_INT:   keep = stl_pkg::is_hex_part(c) || (c == stl_pkg::CH_DOT);
            stl_pkg::MODE_FLOAT: keep = stl_pkg::is_digit(c);
            stl_pkg::MODE_OP:    keep = (length_reg == stl_pkg::LEN_BITS'(1))
                                     && stl_pkg::pair_valid(prefix_reg[7:0], c);
            default:             keep = 1'b0;
        endcase

        if (mode_reg == stl_pkg::MODE_EMPTY || mode_reg > stl_pkg::MODE_OP)
        begin
            // Empty: start a lexeme, skip whitespace or flag a stray byte
            ends = 1'b0;
            if (stl_pkg::is_space(c))
                new_mode = stl_pkg::MODE_EMPTY;
            else if (stl_pkg::is_word_start(c))
                new_mode = stl_pkg::MODE_IDENT;
            else if (stl_pkg::is_digit(c))
                new_mode = stl_pkg::MODE_INT;
            else if (c == stl_pkg::CH_DOT)
                new_mode = stl_pkg::MODE_FLOAT;
            else if (stl_pkg::is_opchar(c))
                new_mode = stl_pkg::MODE_OP;
            else
            begin
                emit       = 1'b1;
                emit_type  = stl_pkg::TOK_ERROR;
                emit_start = offset_reg;
                emit_len   = stl_pkg::LEN_BITS'(1);
                new_mode   = stl_pkg::MODE_EMPTY;
            end
            ends = 1'b1;
        end
        else if (keep)
        begin
            // Grow the lexeme
            for (int i = 0; i < PREFIX_BYTES; i++)
            begin
                if (length_reg == stl_pkg::LEN_BITS'(i))
                    prefix_next[i*stl_pkg::CHAR_BITS +: stl_pkg::CHAR_BITS] = c;
            end
            length_next = len_sat;
            if (mode_reg == stl_pkg::MODE_INT && c == stl_pkg::CH_DOT)
                mode_next = stl_pkg::MODE_FLOAT;
        end
        else
        begin
            // Lexeme ends here, or the byte is invalid inside it
            emit = 1'b1;
            ends = 1'b1;
            if (stl_pkg::is_space(c))
                new_mode = stl_pkg::MODE_EMPTY;
            else if (stl_pkg::is_opchar(c))
                new_mode = stl_pkg::MODE_OP;
            else if (mode_reg == stl_pkg::MODE_OP && stl_pkg::is_word_start(c))
                new_mode = stl_pkg::MODE_IDENT;
            else if (mode_reg == stl_pkg::MODE_OP && stl_pkg::is_digit(c))
                new_mode = stl_pkg::MODE_INT;
            else if (mode_reg == stl_pkg::MODE_OP && c == stl_pkg::CH_DOT)
                new_mode = stl_pkg::MODE_FLOAT;
            else
            begin
                ends     = 1'b0;
                new_mode = stl_pkg::MODE_EMPTY;
            end

            emit_start = start_reg;
            if (ends)
            begin
                emit_type = lexeme_type(mode_reg, prefix_reg, length_reg);
                emit_len  = length_reg;
            end
            else
            begin
                emit_type = stl_pkg::TOK_ERROR;
                emit_len  = len_sat;
                ends      = 1'b1;
            end
        end

        // Clear to empty or open a new lexeme at this byte
        if (ends)
        begin
            mode_next   = new_mode;
            prefix_next = '0;
            if (new_mode == stl_pkg::MODE_EMPTY)
                length_next = '0;
            else
            begin
                start_next            = offset_reg;
                length_next           = stl_pkg::LEN_BITS'(1);
                prefix_next[stl_pkg::CHAR_BITS-1:0] = c;
            end
        end
    end

    // Token start is the offset modulo 2^32
    generate
        if (OFFSET_BITS >= stl_pkg::START_BITS)
        begin : g_start_trunc
            assign emit_start_word = emit_start[stl_pkg::START_BITS-1:0];
        end
        else
        begin : g_start_ext
            assign emit_start_word = {{(stl_pkg::START_BITS-OFFSET_BITS){1'b0}}, emit_start};
        end
    endgenerate

    // Handshake: the scanned byte moves on unless its token has nowhere to go
    assign advance    = byte_valid_reg && (!emit || !token_valid_reg || !token_stall);
    assign char_stall = byte_valid_reg && !advance;
    assign char_take  = char_valid && !char_stall;

    always_comb
    begin
        if (advance && emit)
            token_valid_next = 1'b1;
        else if (!token_stall)
            token_valid_next = 1'b0;
        else
            token_valid_next = token_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg  <= 1'b0;
            token_valid_reg <= 1'b0;
            mode_reg        <= stl_pkg::MODE_EMPTY;
            offset_reg      <= '0;
            start_reg       <= '0;
            length_reg      <= '0;
            prefix_reg      <= '0;
        end
        else
        begin
            token_valid_reg <= token_valid_next;
            if (char_take)
                byte_valid_reg <= 1'b1;
            else if (advance)
                byte_valid_reg <= 1'b0;
            if (advance)
            begin
                mode_reg   <= mode_next;
                offset_reg <= offset_reg + 1'b1;
                start_reg  <= start_next;
                length_reg <= length_next;
                prefix_reg <= prefix_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (char_take)
            byte_reg <= char_code;
        if (advance && emit)
        begin
            type_reg    <= emit_type;
            tstart_reg  <= emit_start_word;
            tlength_reg <= emit_len;
        end
    end

    assign token_valid  = token_valid_reg;
    assign token_type   = type_reg;
    assign token_start  = tstart_reg;
    assign token_length = tlength_reg;

    // An empty scanner holds no lexeme bytes, a live lexeme holds at least one
    a_len_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == stl_pkg::MODE_EMPTY) == (length_reg == '0))
        else $error("lexeme length disagrees with scanner mode");

    // Operator tokens are one or two bytes long
    a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_type >= stl_pkg::TOK_PLUS && token_type <= stl_pkg::TOK_OROR
        |-> (token_length == stl_pkg::LEN_BITS'(1) || token_length == stl_pkg::LEN_BITS'(2)))
        else $error("operator token with bad length");

    // Keywords are never longer than a keyword table entry
    a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_type != stl_pkg::TOK_IDENT && token_type <= stl_pkg::TOK_KW_LAST
        |-> token_length <= stl_pkg::LEN_BITS'(stl_pkg::KW_BYTES))
        else $error("keyword token longer than any keyword");

    // Every scanned byte moves the offset by one
    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> offset_reg == $past(offset_reg) + 1'b1)
        else $error("byte offset did not step");

endmodule
